### sv/heid_pkg.sv
`default_nettype none
package heid_pkg;

    localparam int Rounds     = 64;
    localparam int RoundsPerSt = 2;

    typedef struct packed {
        logic [63:0] instance_high;
        logic [63:0] instance_low;
        logic [63:0] source_high;
        logic [63:0] source_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] id_high;
        logic [63:0] id_low;
    } out_item_t;

    typedef logic [255:0] hstate_t;
    typedef logic [511:0] sched_t;

    // domain tag, 30 ASCII bytes
    localparam logic [239:0] DomainTag =
        240'h72617766_72616d65_2e736365_6e652069_6e737461_6e636520_656e7469_7479;

    localparam hstate_t InitH = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                                 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [15:0] VerMask  = 16'hF000;
    localparam logic [15:0] VerValue = 16'h8000;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one compression round; state is {a,b,c,d,e,f,g,h}, a in the top word
    function automatic hstate_t sha_round(input hstate_t s, input logic [31:0] kw);
        logic [31:0] a, b, c, d, e, f, g, h, s0, s1, ch, mj, t1, t2;
        a = s[255:224]; b = s[223:192]; c = s[191:160]; d = s[159:128];
        e = s[127:96];  f = s[95:64];   g = s[63:32];   h = s[31:0];
        s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
        ch = (e & f) ^ (~e & g);
        t1 = h + s1 + ch + kw;
        s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
        mj = (a & b) ^ (a & c) ^ (b & c);
        t2 = s0 + mj;
        return {t1 + t2, a, b, c, d + t1, e, f, g};
    endfunction

    // schedule window shift: w[t] in the top word, w[t+15] at the bottom
    function automatic sched_t sched_next(input sched_t w);
        logic [31:0] w0, w1, w9, w14, s0, s1;
        w0 = w[511:480]; w1 = w[479:448]; w9 = w[223:192]; w14 = w[63:32];
        s0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
        s1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
        return {w[479:0], w0 + s0 + w9 + s1};
    endfunction

    function automatic hstate_t hadd(input hstate_t x, input hstate_t y);
        hstate_t r;
        for (int i = 0; i < 8; i++) r[32*i +: 32] = x[32*i +: 32] + y[32*i +: 32];
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/heid_stage.sv
`default_nettype none
// Two SHA-256 rounds per register stage, with its own schedule window.
module heid_stage #(
    parameter logic [5:0] FIRST_ROUND = 6'd0
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              valid_in,
    input  wire heid_pkg::hstate_t st_in,
    input  wire heid_pkg::sched_t  w_in,
    input  wire heid_pkg::hstate_t base_in,
    output logic                   valid_out,
    output heid_pkg::hstate_t      st_out,
    output heid_pkg::sched_t       w_out,
    output heid_pkg::hstate_t      base_out
);
    logic              valid_reg;
    heid_pkg::hstate_t st_reg, st_next, base_reg;
    heid_pkg::sched_t  w_reg, w_next;

    // rounds and schedule advance
    always_comb
    begin
        st_next = st_in;
        w_next  = w_in;
        for (int r = 0; r < heid_pkg::RoundsPerSt; r++)
        begin
            st_next = heid_pkg::sha_round(st_next,
                          heid_pkg::round_k(FIRST_ROUND + 6'(r)) + w_next[511:480]);
            w_next  = heid_pkg::sched_next(w_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_reg   <= st_next;
            w_reg    <= w_next;
            base_reg <= base_in;
        end
    end

    assign valid_out = valid_reg;
    assign st_out    = st_reg;
    assign w_out     = w_reg;
    assign base_out  = base_reg;
endmodule
`default_nettype wire

### sv/heid_block.sv
`default_nettype none
// One full compression: 32 stages of two rounds, then the feed-forward add.
module heid_block (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              valid_in,
    input  wire heid_pkg::hstate_t h_in,
    input  wire heid_pkg::sched_t  blk_in,
    output logic                   valid_out,
    output heid_pkg::hstate_t      h_out
);
    localparam int NSt = heid_pkg::Rounds / heid_pkg::RoundsPerSt;

    logic              v   [NSt+1];
    heid_pkg::hstate_t st  [NSt+1];
    heid_pkg::sched_t  w   [NSt+1];
    heid_pkg::hstate_t bs  [NSt+1];
    logic              valid_reg;
    heid_pkg::hstate_t h_reg;

    assign v[0]  = valid_in;
    assign st[0] = h_in;
    assign w[0]  = blk_in;
    assign bs[0] = h_in;

    for (genvar i = 0; i < NSt; i++)
    begin : g_st
        heid_stage #(.FIRST_ROUND(6'(i * heid_pkg::RoundsPerSt))) u_st (
            .clk(clk), .rst_n(rst_n), .advance(advance),
            .valid_in(v[i]), .st_in(st[i]), .w_in(w[i]), .base_in(bs[i]),
            .valid_out(v[i+1]), .st_out(st[i+1]), .w_out(w[i+1]),
            .base_out(bs[i+1])
        );
    end

    // feed-forward into chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= v[NSt];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            h_reg <= heid_pkg::hadd(bs[NSt], st[NSt]);
    end

    assign valid_out = valid_reg;
    assign h_out     = h_reg;
endmodule
`default_nettype wire

### sv/hashed_entity_id_derivation.sv
`default_nettype none
// Channel | dir | payload            | handshake
// in      | in  | in_item_t (4x64)   | in_valid / in_stall
// out     | out | out_item_t (2x64)  | out_valid / out_stall
// One item per cycle while not stalled; two compressions of 32 two-round
// stages plus one feed-forward register each, then the output register.
// Each round stage computes two SHA-256 rounds.
// Reset clears only valid bits. A stall freezes the whole pipeline; an item
// is taken whenever the output register is empty or being emptied.
module hashed_entity_id_derivation (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire heid_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output heid_pkg::out_item_t      out_data
);
    logic              advance;
    heid_pkg::sched_t  blk1, blk2;
    logic              v1, v2;
    heid_pkg::hstate_t h1, h2;
    logic              valid_reg;
    heid_pkg::out_item_t data_reg;
    logic [63:0]       hi, lo;

    assign advance  = !(valid_reg && out_stall);
    assign in_stall = !advance;

    // first block: tag, ids, pad byte and one zero byte
    assign blk1 = {heid_pkg::DomainTag, in_data.instance_high, in_data.instance_low,
                   in_data.source_high, in_data.source_low, 8'h80, 8'h00};

    heid_block u_b1 (
        .clk(clk), .rst_n(rst_n), .advance(advance),
        .valid_in(in_valid), .h_in(heid_pkg::InitH), .blk_in(blk1),
        .valid_out(v1), .h_out(h1)
    );

    // second block: zeros, length 496 bits
    assign blk2 = {496'd0, 16'h01F0};

    heid_block u_b2 (
        .clk(clk), .rst_n(rst_n), .advance(advance),
        .valid_in(v1), .h_in(h1), .blk_in(blk2),
        .valid_out(v2), .h_out(h2)
    );

    assign hi = h2[255:192];
    assign lo = h2[191:128];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= v2;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg.id_high <= {hi[63:16], (hi[15:0] & ~heid_pkg::VerMask)
                                 | heid_pkg::VerValue};
            data_reg.id_low  <= {2'b10, lo[61:0]};
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
    // version and variant bits
    a_ver: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.id_high[15:12] == 4'h8 && out_data.id_low[63:62] == 2'b10)
        else $error("version or variant wrong");
    // input held off only while output is full and stalled
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("spurious input stall");
endmodule
`default_nettype wire

### verif/heid_id_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module heid_id_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_stall,
    input  wire heid_pkg::in_item_t  in_data,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire heid_pkg::out_item_t out_data,
    output int                       fail_count,
    output int                       pending
);
    localparam logic [63:0] VariantKeep = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VariantSet  = 64'h8000_0000_0000_0000;

    heid_pkg::out_item_t ids_due[$];

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one SHA-256 block into the running digest
    function automatic void digest_block(inout logic [31:0] hv[8], input logic [511:0] blk);
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2;
        for (int t = 0; t < 16; t++) w[t] = blk[511 - 32*t -: 32];
        for (int t = 16; t < 64; t++)
        begin
            s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
        e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
        for (int t = 0; t < 64; t++)
        begin
            s1 = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
            t1 = h + s1 + ((e & f) ^ (~e & g)) + heid_pkg::round_k(t[5:0]) + w[t];
            s0 = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
            t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
        hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
    endfunction

    function automatic heid_pkg::out_item_t derive_id(input heid_pkg::in_item_t x);
        logic [1023:0]       msg;
        logic [31:0]         hv[8];
        heid_pkg::out_item_t r;
        msg = {heid_pkg::DomainTag, x.instance_high, x.instance_low, x.source_high,
               x.source_low, 8'h80, 504'd0, 16'h01F0};
        for (int i = 0; i < 8; i++) hv[i] = heid_pkg::InitH[255 - 32*i -: 32];
        digest_block(hv, msg[1023:512]);
        digest_block(hv, msg[511:0]);
        r.id_high = ({hv[0], hv[1]} & ~64'h0000_0000_0000_F000) | 64'h8000;
        r.id_low  = ({hv[2], hv[3]} & VariantKeep) | VariantSet;
        return r;
    endfunction

    assign pending = ids_due.size();

    // predict on each input transfer, compare on each output transfer
    always @(posedge clk)
    begin
        heid_pkg::out_item_t want;
        if (!rst_n)
        begin
            fail_count = 0;
            ids_due.delete();
        end
        else
        begin
            if (in_valid && !in_stall) ids_due = {ids_due, derive_id(in_data)};
            if (out_valid && !out_stall)
            begin
                if (ids_due.size() == 0)
                begin
                    $error("unexpected result %h", out_data);
                    fail_count++;
                end
                else
                begin
                    want = ids_due.pop_front();
                    if (out_data.id_high !== want.id_high)
                    begin
                        $error("id_high expected %h actual %h", want.id_high, out_data.id_high);
                        fail_count++;
                    end
                    if (out_data.id_low !== want.id_low)
                    begin
                        $error("id_low expected %h actual %h", want.id_low, out_data.id_low);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

### verif/tb_hashed_entity_id_derivation.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_hashed_entity_id_derivation;
    localparam int Latency    = 67;
    localparam int RandomIds  = 1650;
    localparam int CycleLimit = 400000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    heid_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    heid_pkg::out_item_t out_data;
    int                  fail_count;
    int                  pending;
    int                  cycles = 0;

    always #1 clk = ~clk;

    hashed_entity_id_derivation dut (.*);

    heid_id_checker checker_i (.*);

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 80);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
        return 0;
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // present one id pair and hold it until transferred
    task automatic send_ids(input logic [63:0] ih, il, sh, sl);
        in_data  <= '{ih, il, sh, sl};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_gap(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // receiver back-pressure: runs with no stall, then random stalls
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if ((cycles / 2000) % 3 == 0) out_stall <= 1'b0;
            else
            begin
                n = gap_len();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n - 1) @(negedge clk);
                    @(negedge clk);
                end
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, single bits and alternating patterns
        send_ids('0, '0, '0, '0);
        send_ids('1, '1, '1, '1);
        send_ids('1, '0, '1, '0);
        send_ids('0, '1, '0, '1);
        send_ids(64'h8000_0000_0000_0000, 64'd1, 64'h8000_0000_0000_0000, 64'd1);
        send_ids(64'd1, 64'h8000_0000_0000_0000, 64'd1, 64'h8000_0000_0000_0000);
        send_ids(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_ids(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_ids(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'h0, 64'h1);

        // drain completely before the random part
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);

        for (int i = 0; i < RandomIds; i++)
        begin
            if (i == RandomIds / 2)
            begin
                in_valid <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
            if ((i / 300) % 2 == 1) send_gap(gap_len());
            send_ids(rand_word(), rand_word(), rand_word(), rand_word());
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (Latency + 10) @(negedge clk);
        if (fail_count == 0 && pending == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
